@@ rtl/mvtm_pkg.sv @@
// ----------------------------------------------------------------------------
// mvtm_pkg
// Shared types and constants of the multi-voice tone mixer: stream field
// layout, function and waveform codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mvtm_pkg;

  // input beat layout (tdata), lowest bit first
  localparam int unsigned IN_TDATA_W     = 104;
  localparam int unsigned OFS_VOICE_IDX  = 0;
  localparam int unsigned OFS_WAVE_TYPE  = 2;
  localparam int unsigned OFS_START_VOL  = 4;
  localparam int unsigned OFS_DECAY      = 20;
  localparam int unsigned OFS_NOTE_LEN   = 36;
  localparam int unsigned OFS_PERIOD     = 52;
  localparam int unsigned OFS_STEP       = 68;
  localparam int unsigned OFS_START_CNT  = 84;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    WAVE_SILENT = 2'd0,
    WAVE_NOISE  = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_SINE   = 2'd3
  } wave_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic load;       // write one voice from the input beat
    logic clear_sum;  // start a new mix
    logic issue;      // send one voice into the pipeline
    logic push;       // move the clamped mix into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic busy;       // a voice is still in flight
    logic out_free;   // output register can take a beat this cycle
  } dp_sts_t;

endpackage

@@ rtl/mvtm_sine_rom.sv @@
// ----------------------------------------------------------------------------
// mvtm_sine_rom
// Constant sine table with registered read. Entries are built at elaboration
// from a Q30 odd Taylor series on the first quadrant, truncated toward zero.
// ----------------------------------------------------------------------------
module mvtm_sine_rom #(
  parameter int unsigned SINE_STEPS = 256,
  parameter int unsigned DAC_BITS   = 12,
  localparam int unsigned RIDX_W    = $clog2(SINE_STEPS),
  localparam int unsigned DW        = DAC_BITS + 1
) (
  input  logic                 clk_i,
  input  logic [RIDX_W-1:0]    idx_i,
  output logic signed [DW-1:0] data_o
);
  import mvtm_pkg::*;

  function automatic logic signed [DW-1:0] sine_entry(input int unsigned n);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rr;
    longint          acc;
    longint          amp;
    longint          v;
    int unsigned     m;
    int unsigned     q;
    int unsigned     r;
    amp = longint'(1) << (DAC_BITS - 1);
    m   = 4 * n;
    q   = m / SINE_STEPS;
    r   = m % SINE_STEPS;
    if (q[0]) begin
      r = SINE_STEPS - r;
    end
    if (r >= SINE_STEPS) begin
      v = amp;
    end else begin
      rr   = longint'(r);
      x    = (HALF_PI_Q30 * rr) / SINE_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      // odd series terms x^3 .. x^15, signs alternating
      term = ((term * x2) >> 30) / 64'd6;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      acc  = acc - longint'(term);
      if (acc < 0) acc = 0;
      v = (acc * amp) >>> 30;
      if (v > amp) v = amp;
    end
    if (q >= 2) v = -v;
    return DW'(v);
  endfunction

  logic signed [DW-1:0] rom_tbl [SINE_STEPS];

  for (genvar g = 0; g < SINE_STEPS; g++) begin : g_tbl
    assign rom_tbl[g] = sine_entry(g);
  end

  always_ff @(posedge clk_i) begin
    data_o <= rom_tbl[idx_i];
  end

endmodule

@@ rtl/mvtm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mvtm_ctrl
// Sequencer: takes input beats, fires voice loads, issues the voices of a
// tick one per cycle, waits for the pipeline to drain and pushes the mix.
// ----------------------------------------------------------------------------
module mvtm_ctrl #(
  parameter int unsigned VOICE_COUNT = 4,
  localparam int unsigned VIDX_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_func_i,
  output mvtm_pkg::dp_cmd_t   cmd_o,
  output logic [VIDX_W-1:0]   issue_idx_o,
  input  mvtm_pkg::dp_sts_t   sts_i
);
  import mvtm_pkg::*;

  localparam logic [VIDX_W-1:0] LastIdx = VIDX_W'(VOICE_COUNT - 1);

  ctrl_state_e       state_q, state_d;
  logic [VIDX_W-1:0] cnt_q, cnt_d;
  logic              accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign issue_idx_o = cnt_q;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.clear_sum = 1'b1;
            state_d         = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + VIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy && sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_push_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!sts_i.busy && sts_i.out_free))
    else $error("mix pushed while pipeline busy or output full");

  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("voice counter not rewound in idle");

  a_issue_fills_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> sts_i.busy)
    else $error("issued voice did not enter the pipeline");
`endif

endmodule

@@ rtl/mvtm_datapath.sv @@
// ----------------------------------------------------------------------------
// mvtm_datapath
// Voice state, four-stage voice pipeline (read, waveform and update, gain
// multiply, accumulate), mix clamp and output register.
// ----------------------------------------------------------------------------
module mvtm_datapath #(
  parameter int unsigned VOICE_COUNT = 4,
  parameter int unsigned SINE_STEPS  = 256,
  parameter int unsigned DAC_BITS    = 12,
  localparam int unsigned VIDX_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvtm_pkg::dp_cmd_t   cmd_i,
  input  logic [VIDX_W-1:0]   issue_idx_i,
  output mvtm_pkg::dp_sts_t   sts_o,
  input  logic [1:0]          voice_index_i,
  input  logic [1:0]          wave_type_i,
  input  logic [15:0]         start_volume_i,
  input  logic [15:0]         decay_rate_i,
  input  logic [15:0]         note_length_i,
  input  logic [15:0]         wave_period_i,
  input  logic [15:0]         phase_step_i,
  input  logic [15:0]         start_counter_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DAC_BITS-1:0] mixed_sample_o
);
  import mvtm_pkg::*;

  localparam int unsigned RIDX_W  = $clog2(SINE_STEPS);
  localparam int unsigned SMP_W   = DAC_BITS + 1;
  localparam int unsigned PROD_W  = SMP_W + 17;
  localparam int unsigned CON_W   = PROD_W - 16;
  localparam int unsigned SUM_W   = DAC_BITS + $clog2(VOICE_COUNT) + 3;
  localparam int unsigned Half    = 2 ** (DAC_BITS - 1);
  localparam int unsigned FullMax = 2 ** DAC_BITS - 1;

  // voice state
  wave_e       kind_q   [VOICE_COUNT];
  logic [15:0] gain_q   [VOICE_COUNT];
  logic [15:0] fade_q   [VOICE_COUNT];
  logic [15:0] remain_q [VOICE_COUNT];
  logic [15:0] cycle_q  [VOICE_COUNT];
  logic [15:0] inc_q    [VOICE_COUNT];
  logic [16:0] phase_q  [VOICE_COUNT];

  logic              load_ok;
  logic [VIDX_W-1:0] load_addr;

  // stage 1
  logic              s1_valid_q;
  logic [VIDX_W-1:0] s1_idx_q;
  wave_e             s1_kind_q;
  logic              s1_act_q;
  logic [16:0]       s1_phase_q;
  logic [15:0]       s1_gain_q;
  logic [15:0]       s1_fade_q;
  logic [15:0]       s1_remain_q;
  logic [15:0]       s1_cycle_q;
  logic [15:0]       s1_inc_q;
  logic [31:0]       s1_lim_q;
  logic signed [SMP_W-1:0] s1_rom;

  // stage 2 / 3
  logic                     s2_valid_q;
  logic signed [SMP_W-1:0]  s2_smp_q;
  logic [15:0]              s2_gain_q;
  logic                     s3_valid_q;
  logic signed [PROD_W-1:0] s3_prod_q;
  logic signed [PROD_W-1:0] prod_d;

  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  mix_ofs;
  logic [DAC_BITS-1:0]      mix_clamped;
  logic signed [CON_W-1:0]  contrib;
  logic                     out_valid_q;
  logic [DAC_BITS-1:0]      out_data_q;

  // stage 0 signals
  logic [31:0]       s0_lim;
  logic [15:0]       s0_red;
  logic [RIDX_W-1:0] s0_ridx;

  // stage 1 signals
  logic [15:0]             lfsr;
  logic                    fb;
  logic [15:0]             lfsr_nx;
  logic [16:0]             sq_inc;
  logic [17:0]             sin_nx;
  logic [16:0]             phase_nx;
  logic signed [SMP_W-1:0] smp;
  logic [32:0]             gain_mult;
  logic                    s1_wr;

  assign load_ok   = cmd_i.load && ({3'b000, voice_index_i} < 5'(VOICE_COUNT));
  assign load_addr = VIDX_W'(voice_index_i);
  assign s1_wr     = s1_valid_q & s1_act_q;

  // ---------------- stage 0: read voice, phase limit, table index
  assign s0_lim = cycle_q[issue_idx_i] * inc_q[issue_idx_i];

  always_comb begin
    s0_red = {7'b0, phase_q[issue_idx_i][16:8]};
    // table index modulo the table size by restoring reduction
    for (int k = 5; k >= 0; k--) begin
      if (s0_red >= 16'(SINE_STEPS << k)) begin
        s0_red = s0_red - 16'(SINE_STEPS << k);
      end
    end
    s0_ridx = RIDX_W'(s0_red);
  end

  mvtm_sine_rom #(
    .SINE_STEPS(SINE_STEPS),
    .DAC_BITS  (DAC_BITS)
  ) u_sine_rom (
    .clk_i (clk_i),
    .idx_i (s0_ridx),
    .data_o(s1_rom)
  );

  always_ff @(posedge clk_i) begin
    s1_idx_q    <= issue_idx_i;
    s1_kind_q   <= kind_q[issue_idx_i];
    s1_act_q    <= (remain_q[issue_idx_i] != 16'd0);
    s1_phase_q  <= phase_q[issue_idx_i];
    s1_gain_q   <= gain_q[issue_idx_i];
    s1_fade_q   <= fade_q[issue_idx_i];
    s1_remain_q <= remain_q[issue_idx_i];
    s1_cycle_q  <= cycle_q[issue_idx_i];
    s1_inc_q    <= inc_q[issue_idx_i];
    s1_lim_q    <= s0_lim;
  end

  // ---------------- stage 1: waveform, phase and gain update
  always_comb begin
    lfsr    = s1_phase_q[15:0];
    fb      = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
    lfsr_nx = {fb, lfsr[15:1]};
    sq_inc  = s1_phase_q + 17'd1;
    sin_nx  = {1'b0, s1_phase_q} + {2'b00, s1_inc_q};
    case (s1_kind_q)
      WAVE_NOISE: begin
        phase_nx = {1'b0, lfsr_nx};
        smp      = SMP_W'({1'b0, lfsr_nx[15 -: DAC_BITS]}) - SMP_W'(Half);
      end
      WAVE_SQUARE: begin
        phase_nx = (sq_inc == {1'b0, s1_cycle_q}) ? 17'd0 : sq_inc;
        if (s1_phase_q < {2'b00, s1_cycle_q[15:1]}) begin
          smp = SMP_W'(Half - 1);
        end else begin
          smp = -SMP_W'(Half);
        end
      end
      WAVE_SINE: begin
        phase_nx = ({14'd0, sin_nx} > s1_lim_q) ? 17'd0 : sin_nx[16:0];
        smp      = s1_rom;
      end
      default: begin
        phase_nx = s1_phase_q;
        smp      = '0;
      end
    endcase
    gain_mult = s1_gain_q * (17'h10000 - {1'b0, s1_fade_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        kind_q[v]   <= WAVE_SILENT;
        gain_q[v]   <= '0;
        fade_q[v]   <= '0;
        remain_q[v] <= '0;
        cycle_q[v]  <= '0;
        inc_q[v]    <= '0;
        phase_q[v]  <= '0;
      end
    end else if (load_ok) begin
      kind_q[load_addr]   <= wave_e'(wave_type_i);
      gain_q[load_addr]   <= start_volume_i;
      fade_q[load_addr]   <= decay_rate_i;
      remain_q[load_addr] <= note_length_i;
      cycle_q[load_addr]  <= wave_period_i;
      inc_q[load_addr]    <= phase_step_i;
      phase_q[load_addr]  <= {1'b0, start_counter_i};
    end else if (s1_wr) begin
      gain_q[s1_idx_q]   <= gain_mult[31:16];
      remain_q[s1_idx_q] <= s1_remain_q - 16'd1;
      phase_q[s1_idx_q]  <= phase_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_smp_q  <= s1_act_q ? smp : '0;
    s2_gain_q <= s1_gain_q;
  end

  // ---------------- stage 2: scale by gain
  always_comb begin
    prod_d = $signed(s2_smp_q) * $signed({1'b0, s2_gain_q});
  end

  always_ff @(posedge clk_i) begin
    s3_prod_q <= prod_d;
  end

  // ---------------- stage 3: accumulate, floor of product over 65536
  assign contrib = s3_prod_q[PROD_W-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (cmd_i.clear_sum) begin
        sum_q <= '0;
      end else if (s3_valid_q) begin
        sum_q <= sum_q + {{(SUM_W - CON_W){contrib[CON_W-1]}}, contrib};
      end
    end
  end

  // ---------------- mid-scale offset and clamp
  always_comb begin
    mix_ofs = sum_q + SUM_W'(Half);
    if (mix_ofs[SUM_W-1]) begin
      mix_clamped = '0;
    end else if (mix_ofs > SUM_W'(FullMax)) begin
      mix_clamped = DAC_BITS'(FullMax);
    end else begin
      mix_clamped = mix_ofs[DAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= mix_clamped;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_data_q;
  assign sts_o.busy     = s1_valid_q | s2_valid_q | s3_valid_q;
  assign sts_o.out_free = !out_valid_q | out_ready_i;

`ifndef SYNTHESIS
  a_no_clear_mid_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> !cmd_i.clear_sum)
    else $error("mix cleared while a voice was accumulating");

  a_push_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten before it was taken");

  a_load_vs_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_wr |-> !cmd_i.load)
    else $error("voice load collided with pipeline writeback");
`endif

endmodule

@@ rtl/multi_voice_tone_mixer.sv @@
// ----------------------------------------------------------------------------
// multi_voice_tone_mixer
// Multi-voice tone mixer: load beats program one voice, tick beats return
// one mixed, offset and clamped DAC sample.
//
//   channel  dir  signals           contents
//   s_axis   in   tdata, tuser      voice load or tick request
//   m_axis   out  tdata             one mixed sample per tick
//
// a load is written into the voice state as it is accepted; a tick issues its
// voices into the voice pipeline one per cycle, and the input is taken again
// once the drained mix has been pushed into the output register
// reset clears all voices to silent with zero gain and length
// the input is taken again while a result waits in the output register; a
// second finished mix holds until that beat is taken
// ----------------------------------------------------------------------------
module multi_voice_tone_mixer #(
  parameter int unsigned VOICE_COUNT = 4,
  parameter int unsigned SINE_STEPS  = 256,
  parameter int unsigned DAC_BITS    = 12,
  localparam int unsigned OUT_W      = ((DAC_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // voice_index, wave_type, start_volume, decay_rate, note_length,
  // wave_period, phase_step, start_counter, zero pad
  input  logic [mvtm_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // func
  input  logic [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // mixed_sample, zero pad
  output logic [OUT_W-1:0]                m_axis_tdata_o
);
  import mvtm_pkg::*;

  localparam int unsigned VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [VIDX_W-1:0]   issue_idx;
  logic [DAC_BITS-1:0] mixed_sample;

  mvtm_ctrl #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_func_i  (s_axis_tuser_i[0]),
    .cmd_o      (cmd),
    .issue_idx_o(issue_idx),
    .sts_i      (sts)
  );

  mvtm_datapath #(
    .VOICE_COUNT(VOICE_COUNT),
    .SINE_STEPS (SINE_STEPS),
    .DAC_BITS   (DAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .issue_idx_i    (issue_idx),
    .sts_o          (sts),
    .voice_index_i  (s_axis_tdata_i[OFS_VOICE_IDX +: 2]),
    .wave_type_i    (s_axis_tdata_i[OFS_WAVE_TYPE +: 2]),
    .start_volume_i (s_axis_tdata_i[OFS_START_VOL +: 16]),
    .decay_rate_i   (s_axis_tdata_i[OFS_DECAY +: 16]),
    .note_length_i  (s_axis_tdata_i[OFS_NOTE_LEN +: 16]),
    .wave_period_i  (s_axis_tdata_i[OFS_PERIOD +: 16]),
    .phase_step_i   (s_axis_tdata_i[OFS_STEP +: 16]),
    .start_counter_i(s_axis_tdata_i[OFS_START_CNT +: 16]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .mixed_sample_o (mixed_sample)
  );

  assign m_axis_tdata_o = OUT_W'(mixed_sample);

endmodule
